// ===== src/ktsc_pkg.sv =====
package ktsc_pkg;

  localparam int unsigned AlphaLen = 32;
  localparam int unsigned LetterW = 5;
  localparam int unsigned CodeW = 6;
  localparam logic [LetterW-1:0] RowShiftReset = 5'd4;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_KEY      = 3'd1,
    OP_COMPLETE = 3'd2,
    OP_ENCRYPT  = 3'd3,
    OP_DECRYPT  = 3'd4,
    OP_RSVD5    = 3'd5,
    OP_RSVD6    = 3'd6,
    OP_RSVD7    = 3'd7
  } op_e;

  typedef struct packed {
    logic clear;
    logic append_key;
    logic fill_step;
    logic lookup;
    logic decrypt;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic fill_last;
  } status_t;

endpackage

// ===== src/ktsc_ram.sv =====
module ktsc_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 32
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ktsc_dp.sv =====
module ktsc_dp #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ktsc_pkg::cmd_t                cmd_i,
  output ktsc_pkg::status_t             status_o,
  input  logic [ktsc_pkg::CodeW-1:0]    letter_i,
  input  logic                          row_shift_we_i,
  input  logic [ktsc_pkg::LetterW-1:0]  row_shift_i,
  output logic [ktsc_pkg::LetterW-1:0]  out_letter_o
);

  localparam int unsigned PosW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned FillW = $clog2(TABLE_SIZE + 1);
  localparam logic [PosW:0] SizeW = (PosW + 1)'(TABLE_SIZE);

  logic [ktsc_pkg::AlphaLen-1:0] present_q, present_d;
  logic [PosW-1:0]               pos_q [ktsc_pkg::AlphaLen];
  logic [FillW-1:0]              fill_q, fill_d;
  logic [ktsc_pkg::LetterW-1:0]  walk_q, walk_d;
  logic [PosW-1:0]               shift_q, shift_d;
  logic [ktsc_pkg::LetterW-1:0]  out_letter_q;

  logic [ktsc_pkg::LetterW-1:0]  key_code, app_code, rdata;
  logic                          key_alpha, app_req, app_en, table_full;
  logic [PosW:0]                 pos_ext, sh_ext, enc_sum, enc_pos, dec_pos;
  logic [PosW-1:0]               tgt_pos, shift_red;

  assign key_code  = letter_i[ktsc_pkg::LetterW-1:0];
  assign key_alpha = !letter_i[ktsc_pkg::CodeW-1];

  // key letters and the completion walk share one append path
  assign app_code   = cmd_i.fill_step ? walk_q : key_code;
  assign app_req    = cmd_i.fill_step || (cmd_i.append_key && key_alpha);
  assign table_full = (fill_q == FillW'(TABLE_SIZE));
  assign app_en     = app_req && !present_q[app_code] && !table_full;

  assign status_o.hit       = key_alpha && present_q[key_code];
  assign status_o.fill_last = (walk_q == ktsc_pkg::LetterW'(ktsc_pkg::AlphaLen - 1));

  // shifted position, both operands already below the table size
  assign pos_ext = {1'b0, pos_q[key_code]};
  assign sh_ext  = {1'b0, shift_q};
  assign enc_sum = pos_ext + sh_ext;
  assign enc_pos = (enc_sum >= SizeW) ? (enc_sum - SizeW) : enc_sum;
  assign dec_pos = (pos_ext >= sh_ext) ? (pos_ext - sh_ext) : (pos_ext + (SizeW - sh_ext));
  assign tgt_pos = cmd_i.decrypt ? dec_pos[PosW-1:0] : enc_pos[PosW-1:0];

  // shift is reduced modulo the table size once, when written
  always_comb begin
    shift_red = '0;
    for (int i = 0; i < ktsc_pkg::AlphaLen; i++) begin
      if (row_shift_i == ktsc_pkg::LetterW'(i)) begin
        shift_red = PosW'(i % TABLE_SIZE);
      end
    end
  end

  always_comb begin
    present_d = present_q;
    fill_d    = fill_q;
    walk_d    = walk_q;
    shift_d   = shift_q;
    if (cmd_i.clear) begin
      present_d = '0;
      fill_d    = '0;
    end else if (app_en) begin
      present_d[app_code] = 1'b1;
      fill_d              = fill_q + FillW'(1);
    end
    if (cmd_i.fill_step) begin
      walk_d = walk_q + ktsc_pkg::LetterW'(1);
    end
    if (row_shift_we_i) begin
      shift_d = shift_red;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      fill_q    <= '0;
      walk_q    <= '0;
      shift_q   <= PosW'(ktsc_pkg::RowShiftReset % TABLE_SIZE);
    end else begin
      present_q <= present_d;
      fill_q    <= fill_d;
      walk_q    <= walk_d;
      shift_q   <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (app_en) begin
      pos_q[app_code] <= fill_q[PosW-1:0];
    end
    if (cmd_i.load_out) begin
      out_letter_q <= rdata;
    end
  end

  ktsc_ram #(
    .Width (ktsc_pkg::LetterW),
    .Depth (TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (app_en),
    .waddr_i (fill_q[PosW-1:0]),
    .wdata_i (app_code),
    .re_i    (cmd_i.lookup),
    .raddr_i (tgt_pos),
    .rdata_o (rdata)
  );

  assign out_letter_o = out_letter_q;

endmodule

// ===== src/ktsc_ctrl.sv =====
module ktsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        operation_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ktsc_pkg::cmd_t    cmd_o,
  input  ktsc_pkg::status_t status_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ
  } state_e;

  state_e         state_q, state_d;
  logic           out_valid_q, out_valid_d;
  ktsc_pkg::op_e  op;

  assign op         = ktsc_pkg::op_e'(operation_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (op)
            ktsc_pkg::OP_CLEAR:    cmd_o.clear = 1'b1;
            ktsc_pkg::OP_KEY:      cmd_o.append_key = 1'b1;
            ktsc_pkg::OP_COMPLETE: state_d = S_FILL;
            ktsc_pkg::OP_ENCRYPT, ktsc_pkg::OP_DECRYPT: begin
              // letters not in the table end the transaction with no result
              if (status_i.hit) begin
                cmd_o.lookup  = 1'b1;
                cmd_o.decrypt = (op == ktsc_pkg::OP_DECRYPT);
                state_d       = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        // table read data holds until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/keyed_table_shift_cipher_core.sv =====
// channel   direction  handshake                payload
// in        input      in_valid_i / in_ready_o  operation_i, letter_i
// out       output     out_valid_o / out_ready_i out_letter_o
// row_shift input      row_shift_we_i           row_shift_i
//
// clear, key letter, an unused code and a letter not in the table are handled in the idle state alone;
// an encrypt or decrypt hit does a position lookup with the table memory read, then the output
// register load, which waits while an earlier result is still held there.
// completing the table walks all 32 letters, one per cycle.
// reset clears the presence bits and fill count and sets the shift to 4; no clearing pass.
// a waiting result does not block new input unless a lookup needs the output register.
module keyed_table_shift_cipher_core #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    operation_i,
  input  logic [ktsc_pkg::CodeW-1:0]    letter_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ktsc_pkg::LetterW-1:0]  out_letter_o,
  input  logic                          row_shift_we_i,
  input  logic [ktsc_pkg::LetterW-1:0]  row_shift_i
);

  ktsc_pkg::cmd_t    cmd;
  ktsc_pkg::status_t status;

  ktsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ktsc_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .letter_i       (letter_i),
    .row_shift_we_i (row_shift_we_i),
    .row_shift_i    (row_shift_i),
    .out_letter_o   (out_letter_o)
  );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam int unsigned TableSize = 32;
  localparam int unsigned CodeW = ktsc_pkg::CodeW;
  localparam int unsigned LetterW = ktsc_pkg::LetterW;
  localparam int unsigned AlphaLen = ktsc_pkg::AlphaLen;
  localparam int unsigned ItemsPerPhase = 260;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit = 400000;

  typedef enum logic [1:0] {EXP_NONE, EXP_VALUE, EXP_PREDICT} exp_mode_e;

  typedef struct packed {
    ktsc_pkg::op_e      op;
    logic [CodeW-1:0]   code;
    exp_mode_e          mode;
    logic [LetterW-1:0] value;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         operation_i;
  logic [CodeW-1:0]   letter_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [LetterW-1:0] out_letter_o;
  logic               row_shift_we_i;
  logic [LetterW-1:0] row_shift_i;

  keyed_table_shift_cipher_core #(.TABLE_SIZE(TableSize)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .letter_i      (letter_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_letter_o  (out_letter_o),
    .row_shift_we_i(row_shift_we_i),
    .row_shift_i   (row_shift_i)
  );

  // shadow of the cipher state
  logic [LetterW-1:0] key_table [TableSize];
  bit                 letter_seen [AlphaLen];
  logic [LetterW-1:0] seen_pos [AlphaLen];
  int unsigned        fill_cnt;
  int unsigned        written_cnt;
  logic [LetterW-1:0] cur_shift;
  logic [LetterW-1:0] pending_out [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent;
  int unsigned err_count;
  int unsigned cycle_count;
  logic [LetterW-1:0] exp_code;

  // directed part, typed expectations read straight off the table layout
  dir_row_t dir_rows [26] = '{
    '{ktsc_pkg::OP_ENCRYPT,  6'd0,  EXP_NONE,    5'd0},  // nothing keyed yet
    '{ktsc_pkg::OP_CLEAR,    6'd0,  EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_KEY,      6'd31, EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_KEY,      6'd31, EXP_NONE,    5'd0},  // repeated key letter
    '{ktsc_pkg::OP_KEY,      6'd32, EXP_NONE,    5'd0},  // non-alphabet symbol
    '{ktsc_pkg::OP_KEY,      6'd63, EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_KEY,      6'd0,  EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_COMPLETE, 6'd0,  EXP_NONE,    5'd0},  // table: 31, 0, 1, 2 ... 30
    '{ktsc_pkg::OP_ENCRYPT,  6'd31, EXP_VALUE,   5'd3},
    '{ktsc_pkg::OP_DECRYPT,  6'd31, EXP_VALUE,   5'd27},
    '{ktsc_pkg::OP_ENCRYPT,  6'd30, EXP_VALUE,   5'd2},  // wraps past the end
    '{ktsc_pkg::OP_DECRYPT,  6'd0,  EXP_VALUE,   5'd28},
    '{ktsc_pkg::OP_ENCRYPT,  6'd32, EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_DECRYPT,  6'd63, EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_RSVD5,    6'd5,  EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_RSVD6,    6'd42, EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_RSVD7,    6'd21, EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_KEY,      6'd7,  EXP_NONE,    5'd0},  // table already full
    '{ktsc_pkg::OP_CLEAR,    6'd63, EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_ENCRYPT,  6'd5,  EXP_NONE,    5'd0},  // cleared, so not present
    '{ktsc_pkg::OP_KEY,      6'd5,  EXP_NONE,    5'd0},
    '{ktsc_pkg::OP_ENCRYPT,  6'd5,  EXP_VALUE,   5'd3},  // stale entry kept over the clear
    '{ktsc_pkg::OP_DECRYPT,  6'd5,  EXP_VALUE,   5'd27},
    '{ktsc_pkg::OP_KEY,      6'd3,  EXP_PREDICT, 5'd0},
    '{ktsc_pkg::OP_COMPLETE, 6'd0,  EXP_PREDICT, 5'd0},
    '{ktsc_pkg::OP_DECRYPT,  6'd17, EXP_PREDICT, 5'd0}
  };

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic void append_key_letter(input int unsigned code);
    if (code >= AlphaLen || letter_seen[code] || fill_cnt >= TableSize) return;
    key_table[fill_cnt] = LetterW'(code);
    seen_pos[code] = LetterW'(fill_cnt);
    letter_seen[code] = 1'b1;
    fill_cnt++;
    if (fill_cnt > written_cnt) written_cnt = fill_cnt;
  endfunction

  function automatic bit is_lookup_hit(input ktsc_pkg::op_e op,
                                       input logic [CodeW-1:0] code);
    return (op == ktsc_pkg::OP_ENCRYPT || op == ktsc_pkg::OP_DECRYPT) &&
           code < AlphaLen && letter_seen[code[LetterW-1:0]];
  endfunction

  function automatic int unsigned shifted_pos(input ktsc_pkg::op_e op,
                                              input logic [CodeW-1:0] code);
    int unsigned p;
    p = seen_pos[code[LetterW-1:0]];
    if (op == ktsc_pkg::OP_ENCRYPT) return (p + cur_shift) % TableSize;
    return (p + TableSize - cur_shift) % TableSize;
  endfunction

  function automatic void cipher_step(input ktsc_pkg::op_e op, input logic [CodeW-1:0] code,
                                      output bit has_out, output logic [LetterW-1:0] out_code);
    has_out = 1'b0;
    out_code = '0;
    case (op)
      ktsc_pkg::OP_CLEAR: begin
        foreach (letter_seen[i]) letter_seen[i] = 1'b0;
        fill_cnt = 0;
      end
      ktsc_pkg::OP_KEY: append_key_letter(code);
      ktsc_pkg::OP_COMPLETE: begin
        for (int unsigned i = 0; i < AlphaLen; i++) append_key_letter(i);
      end
      ktsc_pkg::OP_ENCRYPT, ktsc_pkg::OP_DECRYPT: begin
        if (is_lookup_hit(op, code)) begin
          has_out = 1'b1;
          out_code = key_table[shifted_pos(op, code)];
        end
      end
      default: ;
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge with valid low
  task automatic drive_item(input ktsc_pkg::op_e op, input logic [CodeW-1:0] code,
                            input exp_mode_e mode, input logic [LetterW-1:0] value);
    bit has_out;
    logic [LetterW-1:0] out_code;
    // never look up a table entry that has not been written since reset
    if (is_lookup_hit(op, code) && shifted_pos(op, code) >= written_cnt)
      code = CodeW'(AlphaLen + $urandom_range(0, 31));
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    operation_i = op;
    letter_i = code;
    do @(posedge clk_i); while (!in_ready_o);
    cipher_step(op, code, has_out, out_code);
    case (mode)
      EXP_VALUE:   pending_out.push_back(value);
      EXP_PREDICT: if (has_out) pending_out.push_back(out_code);
      default: ;
    endcase
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // mostly key, complete, then a run of lookups; now and then a burst of noise
  task automatic run_session();
    int unsigned n;
    ktsc_pkg::op_e op;
    logic [CodeW-1:0] code;
    if ($urandom_range(0, 99) < 8) begin
      repeat (5)
        drive_item(ktsc_pkg::op_e'($urandom_range(0, 7)), CodeW'($urandom_range(0, 63)),
                   EXP_PREDICT, '0);
      return;
    end
    if ($urandom_range(0, 9) != 0)
      drive_item(ktsc_pkg::OP_CLEAR, CodeW'($urandom_range(0, 63)), EXP_PREDICT, '0);
    n = $urandom_range(0, 12);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) code = CodeW'($urandom_range(32, 63));
      else code = CodeW'($urandom_range(0, 31));
      drive_item(ktsc_pkg::OP_KEY, code, EXP_PREDICT, '0);
    end
    if ($urandom_range(0, 99) < 85)
      drive_item(ktsc_pkg::OP_COMPLETE, CodeW'($urandom_range(0, 63)), EXP_PREDICT, '0);
    n = $urandom_range(4, 30);
    repeat (n) begin
      op = $urandom_range(0, 1) ? ktsc_pkg::OP_ENCRYPT : ktsc_pkg::OP_DECRYPT;
      if ($urandom_range(0, 19) == 0) op = ktsc_pkg::op_e'($urandom_range(5, 7));
      if (fill_cnt > 0 && $urandom_range(0, 99) < 85)
        code = CodeW'(key_table[$urandom_range(0, fill_cnt - 1)]);
      else
        code = CodeW'($urandom_range(0, 63));
      drive_item(op, code, EXP_PREDICT, '0);
    end
  endtask

  // only once every result is out and a full table completion has had time to finish
  task automatic set_row_shift(input logic [LetterW-1:0] shift_val);
    while (pending_out.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    row_shift_i = shift_val;
    row_shift_we_i = 1'b1;
    @(negedge clk_i);
    row_shift_we_i = 1'b0;
    cur_shift = shift_val;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("out_letter %0d with no transaction waiting", out_letter_o));
      end else begin
        exp_code = pending_out.pop_front();
        if (out_letter_o !== exp_code)
          report_mismatch($sformatf("out_letter %0d, expected %0d", out_letter_o, exp_code));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_out.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = '0;
    letter_i = '0;
    row_shift_we_i = 1'b0;
    row_shift_i = '0;
    send_idle_pct = 11;
    recv_stall_pct = 53;
    items_sent = 0;
    foreach (key_table[i]) key_table[i] = '0;
    foreach (letter_seen[i]) letter_seen[i] = 1'b0;
    foreach (seen_pos[i]) seen_pos[i] = '0;
    fill_cnt = 0;
    written_cnt = 0;
    cur_shift = ktsc_pkg::RowShiftReset;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      drive_item(dir_rows[i].op, dir_rows[i].code, dir_rows[i].mode, dir_rows[i].value);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 11;
          recv_stall_pct = 53;
          set_row_shift('0);
        end
        1: begin
          send_idle_pct = 53;
          recv_stall_pct = 11;
          set_row_shift('1);
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          set_row_shift(LetterW'($urandom_range(1, 30)));
        end
      endcase
      items_sent = 0;
      while (items_sent < ItemsPerPhase) run_session();
    end

    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
